[design/capacitive_key_threshold_tracker_assert.svh]
// Assertion macros used by the tracker checker.
`ifndef CAPACITIVE_KEY_THRESHOLD_TRACKER_ASSERT_SVH
`define CAPACITIVE_KEY_THRESHOLD_TRACKER_ASSERT_SVH

// Check that cond implies consq in the same cycle.
`define CKT_ASSERT_NOW(label, clk, rst_n, cond, consq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (consq)) \
        else $error(msg);

// Check that cond implies consq in the next cycle.
`define CKT_ASSERT_NEXT(label, clk, rst_n, cond, consq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (consq)) \
        else $error(msg);

`endif

[design/ckt_pkg.sv]
// Shared constants, types and codes of the capacitive key threshold tracker.
`default_nettype none
package ckt_pkg;

    localparam int ROWS            = 8;
    localparam int COLS            = 16;
    localparam int STROKE_FULL     = 100;
    localparam int SAMPLE_BITS     = 12;
    localparam int NO_DEFAULT_MARK = 0;

    localparam int KEYS    = ROWS * COLS;
    localparam int KEY_W   = (KEYS > 1) ? $clog2(KEYS) : 1;
    localparam int ROW_W   = 3;
    localparam int COL_W   = 4;
    localparam int SAMPLE_W = SAMPLE_BITS;
    localparam int LVL_W   = 12;
    localparam int FRAC_W  = 7;
    localparam int MODE_W  = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    // Scaling: ((lo + hi) * frac) / STROKE_FULL by reciprocal multiply.
    localparam int SUM_W   = SAMPLE_W + 1;
    localparam int PROD_W  = SUM_W + FRAC_W;
    localparam int DIV_L   = (STROKE_FULL > 1) ? $clog2(STROKE_FULL) : 0;
    localparam int SHIFT   = PROD_W + DIV_L;
    localparam int RECIP_W = PROD_W + 1;
    localparam longint unsigned RECIP =
        ((64'd1 << SHIFT) + 64'(STROKE_FULL) - 64'd1) / 64'(STROKE_FULL);
    localparam int Q_W     = PROD_W + RECIP_W;
    localparam int THR_W   = Q_W - SHIFT;

    localparam logic [SAMPLE_W-1:0] MIN_RESET = {SAMPLE_W{1'b1}};
    localparam logic [SAMPLE_W-1:0] MAX_RESET = '0;
    localparam logic [SAMPLE_W-1:0] NO_DEF    = SAMPLE_W'(NO_DEFAULT_MARK);

    // Operation codes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_LOAD   = 1'b1;

    // Mode codes
    localparam logic [MODE_W-1:0] MODE_DEFAULT  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_AUTO     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CAL      = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RELEASED = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIXED_PRESS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIXED_REL   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CEILING     = 2'd3;

    // Per-key state as read from the key memory, reset values applied.
    typedef struct packed {
        logic [SAMPLE_W-1:0] learn_min;
        logic [SAMPLE_W-1:0] learn_max;
        logic [SAMPLE_W-1:0] def_min;
        logic [SAMPLE_W-1:0] def_max;
        logic [FRAC_W-1:0]   press_frac;
        logic [FRAC_W-1:0]   release_frac;
    } key_state_t;

    // Write request into the key memory.
    typedef struct packed {
        logic                learn_we;
        logic                cal_we;
        logic [KEY_W-1:0]    key;
        logic [SAMPLE_W-1:0] learn_min;
        logic [SAMPLE_W-1:0] learn_max;
        logic [SAMPLE_W-1:0] def_min;
        logic [SAMPLE_W-1:0] def_max;
        logic [FRAC_W-1:0]   press_frac;
        logic [FRAC_W-1:0]   release_frac;
    } key_wr_t;

endpackage
`default_nettype wire

[design/ckt_if.sv]
// Valid/ready channel interfaces for input and result words.
`default_nettype none
interface ckt_in_if import ckt_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                opcode;
    logic [ROW_W-1:0]    row_index;
    logic [COL_W-1:0]    col_index;
    logic [SAMPLE_W-1:0] sample;
    logic                was_down;
    logic [SAMPLE_W-1:0] load_def_min;
    logic [SAMPLE_W-1:0] load_def_max;
    logic [FRAC_W-1:0]   load_press_frac;
    logic [FRAC_W-1:0]   load_release_frac;

    modport source (
        output valid, opcode, row_index, col_index, sample, was_down,
               load_def_min, load_def_max, load_press_frac, load_release_frac,
        input  ready
    );
    modport sink (
        input  valid, opcode, row_index, col_index, sample, was_down,
               load_def_min, load_def_max, load_press_frac, load_release_frac,
        output ready
    );
endinterface

interface ckt_out_if import ckt_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                key_pressed;
    logic [SAMPLE_W-1:0] learned_min;
    logic [SAMPLE_W-1:0] learned_max;

    modport source (output valid, key_pressed, learned_min, learned_max, input ready);
    modport sink   (input  valid, key_pressed, learned_min, learned_max, output ready);
endinterface
`default_nettype wire

[design/ckt_key_mem.sv]
// Per-key learned and calibration memories with valid bits and registered read.
`default_nettype none
module ckt_key_mem import ckt_pkg::*; (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             rd_en,
    input  wire logic [KEY_W-1:0] rd_key,
    input  wire key_wr_t          wr,
    output key_state_t            state
);

    localparam int LEARN_W = 2 * SAMPLE_W;
    localparam int CAL_W   = 2 * SAMPLE_W + 2 * FRAC_W;

    logic [LEARN_W-1:0] learn_mem [KEYS];
    logic [CAL_W-1:0]   cal_mem   [KEYS];
    logic [KEYS-1:0]    learn_vld_reg;
    logic [KEYS-1:0]    cal_vld_reg;

    logic [LEARN_W-1:0] learn_rd_reg;
    logic [CAL_W-1:0]   cal_rd_reg;
    logic               learn_hit_reg;
    logic               cal_hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr.learn_we)
        begin
            learn_mem[wr.key] <= {wr.learn_min, wr.learn_max};
        end
        if (wr.cal_we)
        begin
            cal_mem[wr.key] <= {wr.def_min, wr.def_max, wr.press_frac, wr.release_frac};
        end
        if (rd_en)
        begin
            learn_rd_reg <= learn_mem[rd_key];
            cal_rd_reg   <= cal_mem[rd_key];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            learn_vld_reg <= '0;
            cal_vld_reg   <= '0;
            learn_hit_reg <= 1'b0;
            cal_hit_reg   <= 1'b0;
        end
        else
        begin
            if (wr.learn_we)
            begin
                learn_vld_reg[wr.key] <= 1'b1;
            end
            if (wr.cal_we)
            begin
                cal_vld_reg[wr.key] <= 1'b1;
            end
            if (rd_en)
            begin
                learn_hit_reg <= learn_vld_reg[rd_key];
                cal_hit_reg   <= cal_vld_reg[rd_key];
            end
        end
    end

    // Entries never written read as their reset values.
    always_comb
    begin
        if (learn_hit_reg)
        begin
            {state.learn_min, state.learn_max} = learn_rd_reg;
        end
        else
        begin
            state.learn_min = MIN_RESET;
            state.learn_max = MAX_RESET;
        end
        if (cal_hit_reg)
        begin
            {state.def_min, state.def_max, state.press_frac, state.release_frac} = cal_rd_reg;
        end
        else
        begin
            state.def_min      = '0;
            state.def_max      = NO_DEF;
            state.press_frac   = '0;
            state.release_frac = '0;
        end
    end

endmodule
`default_nettype wire

[design/ckt_scale.sv]
// Two-stage threshold scaler: product, then divide by stroke range via reciprocal.
`default_nettype none
module ckt_scale import ckt_pkg::*; (
    input  wire logic              clk,
    input  wire logic              mul_en,
    input  wire logic              div_en,
    input  wire logic [SUM_W-1:0]  sum,
    input  wire logic [FRAC_W-1:0] frac,
    output logic      [THR_W-1:0]  level
);

    localparam logic [RECIP_W-1:0] RECIP_V = RECIP_W'(RECIP);

    logic [PROD_W-1:0] prod_reg;
    logic [Q_W-1:0]    quot_reg;

    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_reg <= PROD_W'(sum) * PROD_W'(frac);
        end
        if (div_en)
        begin
            quot_reg <= Q_W'(prod_reg) * Q_W'(RECIP_V);
        end
    end

    assign level = quot_reg[Q_W-1:SHIFT];

endmodule
`default_nettype wire

[design/capacitive_key_threshold_tracker.sv]
// Top level: capacitive key press detector with per-key threshold tracking.
// Sequence: an accepted word passes the update, multiply, reciprocal divide and finish
//   states in order, then the result register; input is ready only in idle, so one
//   word is in flight at a time; a stalled result holds in finish.
// Reset: asynchronous active low; control and configuration registers take their
//   defaults and all key entries read as their reset values at once via per-entry valid bits.
`default_nettype none
module capacitive_key_threshold_tracker import ckt_pkg::*; (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    ckt_in_if.sink                     in_ch,
    ckt_out_if.source                  out_ch,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CALC = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // Configuration registers
    logic [MODE_W-1:0] mode_reg;
    logic [LVL_W-1:0]  fixed_press_reg;
    logic [LVL_W-1:0]  fixed_rel_reg;
    logic [LVL_W-1:0]  ceiling_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_DEFAULT;
            fixed_press_reg <= LVL_W'(1500);
            fixed_rel_reg   <= LVL_W'(1000);
            ceiling_reg     <= LVL_W'(4095);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MODE:        mode_reg        <= cfg_data[MODE_W-1:0];
                CFG_FIXED_PRESS: fixed_press_reg <= cfg_data[LVL_W-1:0];
                CFG_FIXED_REL:   fixed_rel_reg   <= cfg_data[LVL_W-1:0];
                CFG_CEILING:     ceiling_reg     <= cfg_data[LVL_W-1:0];
                default:         ;
            endcase
        end
    end

    // Captured input word
    logic                op_reg;
    logic                inr_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [SAMPLE_W-1:0] value_reg;
    logic                was_down_reg;
    logic [SAMPLE_W-1:0] ld_min_reg;
    logic [SAMPLE_W-1:0] ld_max_reg;
    logic [FRAC_W-1:0]   ld_press_reg;
    logic [FRAC_W-1:0]   ld_rel_reg;

    // Values settled in the update step
    logic [SAMPLE_W-1:0] min_out_reg;
    logic [SAMPLE_W-1:0] max_out_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [FRAC_W-1:0]   frac_reg;
    logic                use_scale_reg;
    logic [LVL_W-1:0]    fixed_thr_reg;
    logic                judge_reg;

    // Result register
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                key_pressed_reg;
    logic [SAMPLE_W-1:0] res_min_reg;
    logic [SAMPLE_W-1:0] res_max_reg;

    logic             accept;
    logic             in_range;
    logic [KEY_W-1:0] key_in;

    assign in_ch.ready = (state_reg == S_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;
    assign in_range    = (int'(in_ch.row_index) < ROWS) && (int'(in_ch.col_index) < COLS);
    assign key_in      = KEY_W'(int'(in_ch.row_index) * COLS + int'(in_ch.col_index));

    // Key memory: read on accept, data available in the update step.
    // One word is in flight at a time, so the write-back of a key always
    // lands before the next read of any key.
    key_state_t ks;
    key_wr_t    wr;

    ckt_key_mem u_mem (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_en  (accept && in_range),
        .rd_key (key_in),
        .wr     (wr),
        .state  (ks)
    );

    // Update step: new learned min and max, level source selection.
    logic [SAMPLE_W-1:0] min_new;
    logic [SAMPLE_W-1:0] max_new;
    logic                use_def;
    logic                use_scale;
    logic [SUM_W-1:0]    sum_sel;
    logic [FRAC_W-1:0]   frac_sel;

    always_comb
    begin
        min_new = (ks.learn_min > value_reg) ? value_reg : ks.learn_min;
        if (ks.learn_max < value_reg)
        begin
            // Overshoot clamps to the ceiling, which may lower a stale max
            max_new = (value_reg > ceiling_reg) ? ceiling_reg : value_reg;
        end
        else
        begin
            max_new = ks.learn_max;
        end

        use_def  = (mode_reg == MODE_DEFAULT) && (ks.def_max != NO_DEF);
        frac_sel = was_down_reg ? ks.release_frac : ks.press_frac;
        if (use_def)
        begin
            use_scale = 1'b1;
            sum_sel   = SUM_W'(ks.def_min) + SUM_W'(ks.def_max);
        end
        else
        begin
            // Learned calibration only once the learned max beats the press level
            use_scale = max_new > fixed_press_reg;
            sum_sel   = SUM_W'(min_new) + SUM_W'(max_new);
        end

        wr.learn_we     = (state_reg == S_CALC) && inr_reg && (op_reg == OP_SAMPLE);
        wr.cal_we       = (state_reg == S_CALC) && inr_reg && (op_reg == OP_LOAD);
        wr.key          = key_reg;
        wr.learn_min    = min_new;
        wr.learn_max    = max_new;
        wr.def_min      = ld_min_reg;
        wr.def_max      = ld_max_reg;
        wr.press_frac   = ld_press_reg;
        wr.release_frac = ld_rel_reg;
    end

    // Scaler: multiply in S_MUL, reciprocal divide in S_DIV.
    logic [THR_W-1:0] scaled_level;

    ckt_scale u_scale (
        .clk    (clk),
        .mul_en (state_reg == S_MUL),
        .div_en (state_reg == S_DIV),
        .sum    (sum_reg),
        .frac   (frac_reg),
        .level  (scaled_level)
    );

    logic down_fin;
    logic fin_take;

    always_comb
    begin
        if (use_scale_reg)
        begin
            down_fin = judge_reg && (32'(value_reg) > 32'(scaled_level));
        end
        else
        begin
            down_fin = judge_reg && (32'(value_reg) > 32'(fixed_thr_reg));
        end
    end

    // Finish only when the result register is free or being drained.
    assign fin_take = (state_reg == S_FIN) && (!out_valid_reg || out_ch.ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (accept) state_next = S_CALC;
            S_CALC: state_next = S_MUL;
            S_MUL:  state_next = S_DIV;
            S_DIV:  state_next = S_FIN;
            S_FIN:  if (fin_take) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase

        out_valid_next = out_valid_reg;
        if (fin_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg       <= in_ch.opcode;
            inr_reg      <= in_range;
            key_reg      <= key_in;
            value_reg    <= in_ch.sample;
            was_down_reg <= in_ch.was_down;
            ld_min_reg   <= in_ch.load_def_min;
            ld_max_reg   <= in_ch.load_def_max;
            ld_press_reg <= in_ch.load_press_frac;
            ld_rel_reg   <= in_ch.load_release_frac;
        end
        if (state_reg == S_CALC)
        begin
            if (!inr_reg)
            begin
                // Off-matrix position: report all zero
                min_out_reg <= '0;
                max_out_reg <= '0;
            end
            else if (op_reg == OP_LOAD)
            begin
                min_out_reg <= ks.learn_min;
                max_out_reg <= ks.learn_max;
            end
            else
            begin
                min_out_reg <= min_new;
                max_out_reg <= max_new;
            end
            sum_reg       <= sum_sel;
            frac_reg      <= frac_sel;
            use_scale_reg <= use_scale;
            fixed_thr_reg <= was_down_reg ? fixed_rel_reg : fixed_press_reg;
            judge_reg     <= inr_reg && (op_reg == OP_SAMPLE) && (mode_reg != MODE_RELEASED);
        end
        if (fin_take)
        begin
            key_pressed_reg <= down_fin;
            res_min_reg     <= min_out_reg;
            res_max_reg     <= max_out_reg;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.key_pressed = key_pressed_reg;
    assign out_ch.learned_min = res_min_reg;
    assign out_ch.learned_max = res_max_reg;

endmodule
`default_nettype wire

[design/ckt_checker.sv]
// Port-level checker for the tracker and its bind to the top level.
`default_nettype none
`include "capacitive_key_threshold_tracker_assert.svh"
module ckt_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready
);

    logic in_acc;
    assign in_acc = in_valid && in_ready;

    `CKT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result word dropped while stalled")
    `CKT_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_acc, !in_ready, "second word taken while one is in flight")
    `CKT_ASSERT_NEXT(a_no_early_result, clk, rst_n, in_acc, !$rose(out_valid), "result word appeared right after accept")

endmodule

bind capacitive_key_threshold_tracker ckt_checker u_ckt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready)
);
`default_nettype wire

[tb/tb.sv]
// Self-checking bench for the capacitive key threshold tracker: table, random keys, scoreboard.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ckt_pkg::*;

    // Run shape: words per random phase, pause after the last result, stall limits.
    localparam int NUM_SCRIPT      = 22;
    localparam int NUM_PHASES      = 6;
    localparam int WORDS_PER_PHASE = 115;
    localparam int SETTLE_CYCLES   = 12;
    localparam int HOLD_CYCLES     = 300;
    localparam int STALL_LIMIT     = 5000;
    localparam int SQUEEZE_PHASE   = 4;

    // One input word as the bench sees it, and the result word it causes.
    typedef struct packed {
        logic                opcode;
        logic [ROW_W-1:0]    row_index;
        logic [COL_W-1:0]    col_index;
        logic [SAMPLE_W-1:0] sample;
        logic                was_down;
        logic [SAMPLE_W-1:0] def_min;
        logic [SAMPLE_W-1:0] def_max;
        logic [FRAC_W-1:0]   press_frac;
        logic [FRAC_W-1:0]   release_frac;
    } key_word_t;

    typedef struct packed {
        logic                key_pressed;
        logic [SAMPLE_W-1:0] learned_min;
        logic [SAMPLE_W-1:0] learned_max;
    } key_result_t;

    // A directed row: the word, and a typed result where it is plain to see.
    typedef struct packed {
        key_word_t   word;
        logic        typed;
        key_result_t want;
    } script_row_t;

    // Register settings and idle profile of one random phase.
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [LVL_W-1:0]  press_lvl;
        logic [LVL_W-1:0]  release_lvl;
        logic [LVL_W-1:0]  ceiling;
        logic [6:0]        send_pct;
        logic [6:0]        recv_pct;
    } phase_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ckt_in_if  in_ch ();
    ckt_out_if out_ch ();

    capacitive_key_threshold_tracker uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Directed words: reset state, field extremes, both operations, hysteresis on
    // either side of a default level, fixed levels while the learned max is low,
    // fractions above full stroke. Rows with typed = 0 go to the predictor.
    script_row_t script [NUM_SCRIPT] = '{
        '{'{OP_SAMPLE, 0,  0,    0, 0,     0,     0,    0,    0}, 1, '{0,    0,    0}},
        '{'{OP_SAMPLE, 7, 15, 4095, 0,  4095,  4095,  127,  127}, 1, '{1, 4095, 4095}},
        '{'{OP_LOAD,   3,  5, 4095, 1,     0,     0,    0,    0}, 1, '{0, 4095,    0}},
        '{'{OP_LOAD,   2,  9,    0, 0,  4095,  4095,  100,  100}, 1, '{0, 4095,    0}},
        '{'{OP_SAMPLE, 2,  9, 4095, 0,     0,     0,    0,    0}, 1, '{0, 4095, 4095}},
        '{'{OP_SAMPLE, 2,  9, 4095, 1,     0,     0,    0,    0}, 1, '{0, 4095, 4095}},
        '{'{OP_LOAD,   1,  1,    0, 0,   100,  1100,   50,   40}, 1, '{0, 4095,    0}},
        '{'{OP_SAMPLE, 1,  1,  601, 0,     0,     0,    0,    0}, 1, '{1,  601,  601}},
        '{'{OP_SAMPLE, 1,  1,  481, 1,     0,     0,    0,    0}, 1, '{1,  481,  601}},
        '{'{OP_SAMPLE, 1,  1,  480, 1,     0,     0,    0,    0}, 1, '{0,  480,  601}},
        '{'{OP_SAMPLE, 1,  1,  600, 0,     0,     0,    0,    0}, 1, '{0,  480,  601}},
        '{'{OP_LOAD,   1,  2,    0, 0,  4095,  4095,  127,  127}, 0, '{0,    0,    0}},
        '{'{OP_SAMPLE, 1,  2, 4095, 0,     0,     0,    0,    0}, 0, '{0,    0,    0}},
        '{'{OP_SAMPLE, 0,  1, 1501, 0,     0,     0,    0,    0}, 0, '{0,    0,    0}},
        '{'{OP_SAMPLE, 0,  2, 1500, 0,     0,     0,    0,    0}, 1, '{0, 1500, 1500}},
        '{'{OP_SAMPLE, 0,  3, 1001, 1,     0,     0,    0,    0}, 1, '{1, 1001, 1001}},
        '{'{OP_SAMPLE, 0,  3, 1000, 1,     0,     0,    0,    0}, 1, '{0, 1000, 1001}},
        '{'{OP_SAMPLE, 0,  0, 4095, 1,     0,     0,    0,    0}, 0, '{0,    0,    0}},
        '{'{OP_LOAD,   0,  0,    0, 0,     0,  4095,   60,   30}, 0, '{0,    0,    0}},
        '{'{OP_SAMPLE, 0,  0, 2000, 0,     0,     0,    0,    0}, 0, '{0,    0,    0}},
        '{'{OP_SAMPLE, 0,  0, 2458, 0,     0,     0,    0,    0}, 0, '{0,    0,    0}},
        '{'{OP_LOAD,   4,  8, 1445, 0,  2650,  4095,   85,   42}, 0, '{0,    0,    0}}
    };

    // Random phases: first the sender idles lightly and the receiver heavily, then
    // the reverse, then neither. Extremes of every register fall somewhere here.
    phase_t phases [NUM_PHASES] = '{
        '{MODE_AUTO,     1500, 1000, 4095, 27, 64},
        '{MODE_DEFAULT,  4095,    0, 3000, 27, 64},
        '{MODE_CAL,         0, 4095,    0, 64, 27},
        '{MODE_RELEASED, 2000,  800, 4095, 64, 27},
        '{MODE_DEFAULT,  1200,  700, 2500,  0,  0},
        '{MODE_AUTO,      900,  400, 1800,  0,  0}
    };

    // Keys that most random words hit, so learned ranges build up and calibrations stick.
    int hot_keys [8] = '{0, 1, 2, 3, 17, 18, 41, 127};

    // Predictor copy of the per-key stores and the registers.
    logic [SAMPLE_W-1:0] seen_min    [KEYS];
    logic [SAMPLE_W-1:0] seen_max    [KEYS];
    logic [SAMPLE_W-1:0] cal_min     [KEYS];
    logic [SAMPLE_W-1:0] cal_max     [KEYS];
    logic [FRAC_W-1:0]   cal_press   [KEYS];
    logic [FRAC_W-1:0]   cal_release [KEYS];
    logic [MODE_W-1:0]   cur_mode;
    logic [LVL_W-1:0]    cur_press_lvl;
    logic [LVL_W-1:0]    cur_release_lvl;
    logic [LVL_W-1:0]    cur_ceiling;

    key_result_t pending_results [$];

    int  send_idle_pct = 27;
    int  recv_idle_pct = 64;
    logic squeeze_req  = 1'b0;
    logic squeeze_done = 1'b0;
    int  hold_left     = 0;
    int  quiet_cycles  = 0;
    int  errors        = 0;
    int  words_sent    = 0;
    int  loads_sent    = 0;
    int  results_checked = 0;
    int  pressed_seen  = 0;

    // ((lo + hi) * frac) / STROKE_FULL at full width; may land above the sample range.
    function automatic int scale_level(logic [SAMPLE_W-1:0] lo, logic [SAMPLE_W-1:0] hi,
                                       logic [FRAC_W-1:0] frac);
        return ((int'(lo) + int'(hi)) * int'(frac)) / STROKE_FULL;
    endfunction

    // Level that the sample must exceed: release level if the key was down, else press.
    // Default mode uses the key's default calibration unless it carries the no-default
    // mark; otherwise take the learned range once its max is above the fixed press level.
    function automatic int key_level(int k, logic was_down);
        logic [FRAC_W-1:0] frac;
        frac = was_down ? cal_release[k] : cal_press[k];
        if (cur_mode == MODE_DEFAULT && cal_max[k] != NO_DEF)
            return scale_level(cal_min[k], cal_max[k], frac);
        if (seen_max[k] > cur_press_lvl)
            return scale_level(seen_min[k], seen_max[k], frac);
        return was_down ? int'(cur_release_lvl) : int'(cur_press_lvl);
    endfunction

    // Advance the predictor by one accepted word and return the result it causes.
    function automatic key_result_t track_key(key_word_t w);
        key_result_t r;
        int k;
        r = '0;
        if (int'(w.row_index) >= ROWS || int'(w.col_index) >= COLS)
            return r;
        k = int'(w.row_index) * COLS + int'(w.col_index);
        if (w.opcode == OP_LOAD)
        begin
            cal_min[k]     = w.def_min;
            cal_max[k]     = w.def_max;
            cal_press[k]   = w.press_frac;
            cal_release[k] = w.release_frac;
        end
        else
        begin
            if (seen_min[k] > w.sample)
                seen_min[k] = w.sample;
            // Overshoot clamps to the ceiling, which may pull an old max down.
            if (seen_max[k] < w.sample)
                seen_max[k] = (w.sample > cur_ceiling) ? cur_ceiling : w.sample;
            if (cur_mode != MODE_RELEASED)
                r.key_pressed = (int'(w.sample) > key_level(k, w.was_down));
        end
        r.learned_min = seen_min[k];
        r.learned_max = seen_max[k];
        return r;
    endfunction

    // Random word: mostly samples on hot keys, a quarter of them placed right at the
    // level that decides the key, the rest spread low, high and anywhere.
    function automatic key_word_t make_word();
        key_word_t w;
        int k;
        int lvl;
        int pick;
        if ($urandom_range(99) < 70)
            k = hot_keys[$urandom_range(7)];
        else
            k = int'($urandom_range(KEYS - 1));
        w.row_index = ROW_W'(k / COLS);
        w.col_index = COL_W'(k % COLS);
        w.opcode    = ($urandom_range(99) < 12) ? OP_LOAD : OP_SAMPLE;
        w.was_down  = 1'($urandom_range(1));
        w.def_min   = ($urandom_range(99) < 70) ? SAMPLE_W'($urandom_range(1500))
                                                : SAMPLE_W'($urandom());
        pick = int'($urandom_range(99));
        if (pick < 20)
            w.def_max = NO_DEF;
        else if (pick < 80)
            w.def_max = SAMPLE_W'($urandom_range(4095, 1000));
        else
            w.def_max = SAMPLE_W'($urandom());
        w.press_frac   = ($urandom_range(99) < 85) ? FRAC_W'($urandom_range(STROKE_FULL))
                                                   : FRAC_W'($urandom());
        w.release_frac = ($urandom_range(99) < 85) ? FRAC_W'($urandom_range(STROKE_FULL))
                                                   : FRAC_W'($urandom());
        pick = int'($urandom_range(99));
        lvl  = key_level(k, w.was_down) + int'($urandom_range(8)) - 4;
        if (pick < 30)
            w.sample = SAMPLE_W'($urandom());
        else if (pick < 55 && lvl <= 4095)
            w.sample = (lvl < 0) ? '0 : SAMPLE_W'(lvl);
        else if (pick < 78)
            w.sample = SAMPLE_W'($urandom_range(800));
        else
            w.sample = SAMPLE_W'($urandom_range(4095, 2800));
        return w;
    endfunction

    // Offer one word after a random gap; on acceptance, log what it should produce.
    // Valid stays high on return so back-to-back words need no second drive.
    task automatic send_word(key_word_t w, logic typed, key_result_t want);
        key_result_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid             <= 1'b1;
        in_ch.opcode            <= w.opcode;
        in_ch.row_index         <= w.row_index;
        in_ch.col_index         <= w.col_index;
        in_ch.sample            <= w.sample;
        in_ch.was_down          <= w.was_down;
        in_ch.load_def_min      <= w.def_min;
        in_ch.load_def_max      <= w.def_max;
        in_ch.load_press_frac   <= w.press_frac;
        in_ch.load_release_frac <= w.release_frac;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        predicted = track_key(w);
        pending_results.push_back(typed ? want : predicted);
        words_sent++;
        if (w.opcode == OP_LOAD)
            loads_sent++;
    endtask

    // Hold one register write for a single edge; the caller drops the enable.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // Drain every expected result, then give the pipeline its latency to go quiet.
    task automatic settle();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Receiver: random back-pressure, plus one long hold-off while the sender keeps
    // offering, so the pipeline fills and input ready drops.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else if (hold_left > 0)
        begin
            out_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end
        else if (squeeze_req && !squeeze_done)
        begin
            out_ch.ready <= 1'b0;
            hold_left    <= HOLD_CYCLES;
            squeeze_done <= 1'b1;
        end
        else
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Scoreboard: compare each result word with the oldest pending expectation.
    always @(posedge clk)
    begin : check_results
        key_result_t want;
        key_result_t got;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = '{out_ch.key_pressed, out_ch.learned_min, out_ch.learned_max};
            if (pending_results.size() == 0)
            begin
                $display("%0t: result word with nothing pending: pressed=%0b min=%0d max=%0d",
                         $time, got.key_pressed, got.learned_min, got.learned_max);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                results_checked++;
                if (want.key_pressed)
                    pressed_seen++;
                if (got.key_pressed !== want.key_pressed)
                begin
                    $display("%0t: key_pressed mismatch, expected %0b, actual %0b",
                             $time, want.key_pressed, got.key_pressed);
                    errors++;
                end
                if (got.learned_min !== want.learned_min)
                begin
                    $display("%0t: learned_min mismatch, expected %0d, actual %0d",
                             $time, want.learned_min, got.learned_min);
                    errors++;
                end
                if (got.learned_max !== want.learned_max)
                begin
                    $display("%0t: learned_max mismatch, expected %0d, actual %0d",
                             $time, want.learned_max, got.learned_max);
                    errors++;
                end
            end
        end
    end

    // Watchdog: end the run if no word moves on either channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: watchdog, no word moved for %0d cycles, %0d results pending",
                     $time, quiet_cycles, pending_results.size());
            $display("tb failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        // Known values on every input from time zero; predictor at its reset state.
        in_ch.valid             <= 1'b0;
        in_ch.opcode            <= OP_SAMPLE;
        in_ch.row_index         <= '0;
        in_ch.col_index         <= '0;
        in_ch.sample            <= '0;
        in_ch.was_down          <= 1'b0;
        in_ch.load_def_min      <= '0;
        in_ch.load_def_max      <= '0;
        in_ch.load_press_frac   <= '0;
        in_ch.load_release_frac <= '0;
        cfg_we                  <= 1'b0;
        cfg_index               <= CFG_MODE;
        cfg_data                <= '0;
        for (int k = 0; k < KEYS; k++)
        begin
            seen_min[k]    = MIN_RESET;
            seen_max[k]    = MAX_RESET;
            cal_min[k]     = '0;
            cal_max[k]     = NO_DEF;
            cal_press[k]   = '0;
            cal_release[k] = '0;
        end
        cur_mode        = MODE_DEFAULT;
        cur_press_lvl   = LVL_W'(1500);
        cur_release_lvl = LVL_W'(1000);
        cur_ceiling     = LVL_W'(4095);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words run on the reset settings.
        foreach (script[i])
            send_word(script[i].word, script[i].typed, script[i].want);
        in_ch.valid <= 1'b0;
        settle();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            // Block is idle here: rewrite all four registers, then mirror them.
            write_reg(CFG_MODE,        CFG_DATA_W'(phases[p].mode));
            write_reg(CFG_FIXED_PRESS, CFG_DATA_W'(phases[p].press_lvl));
            write_reg(CFG_FIXED_REL,   CFG_DATA_W'(phases[p].release_lvl));
            write_reg(CFG_CEILING,     CFG_DATA_W'(phases[p].ceiling));
            cfg_we <= 1'b0;
            cur_mode        = phases[p].mode;
            cur_press_lvl   = phases[p].press_lvl;
            cur_release_lvl = phases[p].release_lvl;
            cur_ceiling     = phases[p].ceiling;

            send_idle_pct = int'(phases[p].send_pct);
            recv_idle_pct <= int'(phases[p].recv_pct);
            if (p == SQUEEZE_PHASE)
                squeeze_req <= 1'b1;

            repeat (WORDS_PER_PHASE)
                send_word(make_word(), 1'b0, '0);
            in_ch.valid <= 1'b0;
            settle();
        end

        $display("covered %0d key words (%0d calibration loads) over %0d register settings",
                 words_sent, loads_sent, NUM_PHASES + 1);
        $display("checked %0d result words, %0d judged pressed, %0d mismatches",
                 results_checked, pressed_seen, errors);
        if (errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
